// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when synthesising
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: rtl/vtpg_pkg.sv
// ---------------------------------------------------------------------------
// vtpg_pkg
// shared types, register indexes, levels and defaults of the timing generator
// ---------------------------------------------------------------------------
package vtpg_pkg;

  localparam int CNT_W              = 16;
  localparam int PIX_TICK_W         = 8;
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_DATA_W         = 16;
  localparam int BOTTOM_BLANK_LINES = 12;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_HSYNC       = 3'd0;
  localparam cfg_idx_t REG_FRONT_PORCH = 3'd1;
  localparam cfg_idx_t REG_BACK_PORCH  = 3'd2;
  localparam cfg_idx_t REG_LINE_REST   = 3'd3;
  localparam cfg_idx_t REG_PIXEL       = 3'd4;

  localparam logic [CNT_W-1:0]      HSYNC_RST       = 16'd82;
  localparam logic [CNT_W-1:0]      FRONT_PORCH_RST = 16'd50;
  localparam logic [CNT_W-1:0]      BACK_PORCH_RST  = 16'd70;
  localparam logic [CNT_W-1:0]      LINE_REST_RST   = 16'd1166;
  localparam logic [PIX_TICK_W-1:0] PIXEL_RST       = 8'd12;

  typedef logic [1:0] level_t;

  localparam level_t LVL_ZERO  = 2'd0;
  localparam level_t LVL_BLACK = 2'd1;
  localparam level_t LVL_GRAY  = 2'd2;
  localparam level_t LVL_WHITE = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0]      hsync_ticks;
    logic [CNT_W-1:0]      front_porch_ticks;
    logic [CNT_W-1:0]      back_porch_ticks;
    logic [CNT_W-1:0]      line_rest_ticks;
    logic [PIX_TICK_W-1:0] pixel_ticks;
  } cfg_t;

  typedef struct packed {
    level_t level;
    logic   line_start;
    logic   frame_start;
  } result_t;

  function automatic level_t pattern_level(input logic [1:0] phase);
    level_t lvl;
    unique case (phase)
      2'd0:    lvl = LVL_BLACK;
      2'd1:    lvl = LVL_GRAY;
      2'd2:    lvl = LVL_BLACK;
      default: lvl = LVL_WHITE;
    endcase
    return lvl;
  endfunction

endpackage

// File: rtl/vtpg_cfg.sv
// ---------------------------------------------------------------------------
// vtpg_cfg
// segment length registers, written through the plain write port
// ---------------------------------------------------------------------------
module vtpg_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  vtpg_pkg::cfg_idx_t                  cfg_index,
  input  logic [vtpg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output vtpg_pkg::cfg_t                      cfg_o
);

  vtpg_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hsync_ticks       <= vtpg_pkg::HSYNC_RST;
      cfg_r.front_porch_ticks <= vtpg_pkg::FRONT_PORCH_RST;
      cfg_r.back_porch_ticks  <= vtpg_pkg::BACK_PORCH_RST;
      cfg_r.line_rest_ticks   <= vtpg_pkg::LINE_REST_RST;
      cfg_r.pixel_ticks       <= vtpg_pkg::PIXEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vtpg_pkg::REG_HSYNC:       cfg_r.hsync_ticks       <= cfg_wdata;
        vtpg_pkg::REG_FRONT_PORCH: cfg_r.front_porch_ticks <= cfg_wdata;
        vtpg_pkg::REG_BACK_PORCH:  cfg_r.back_porch_ticks  <= cfg_wdata;
        vtpg_pkg::REG_LINE_REST:   cfg_r.line_rest_ticks   <= cfg_wdata;
        vtpg_pkg::REG_PIXEL:
          cfg_r.pixel_ticks <= cfg_wdata[vtpg_pkg::PIX_TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

// File: rtl/vtpg_timing.sv
// ---------------------------------------------------------------------------
// vtpg_timing
// segment, pixel, line and frame counters with the level of the current tick
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vtpg_timing #(
  parameter int ACTIVE_LINES     = 242,
  parameter int PIXELS_PER_LINE  = 87,
  parameter int FRAMES_PER_SHIFT = 20,
  parameter int ROWS_PER_SHIFT   = 20,
  parameter int TOP_BLANK_LINES  = 5,
  parameter int VSYNC_LINES      = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_i,
  input  logic              tick_i,
  input  vtpg_pkg::cfg_t    cfg_i,
  output vtpg_pkg::result_t res_o
);

  localparam int TOTAL_LINES = ACTIVE_LINES + TOP_BLANK_LINES + VSYNC_LINES
                               + vtpg_pkg::BOTTOM_BLANK_LINES;
  localparam int LINE_W = $clog2(TOTAL_LINES + 1);
  localparam int PIX_W  = $clog2(PIXELS_PER_LINE + 1);
  localparam int RIG_W  = $clog2(ROWS_PER_SHIFT + 1);
  localparam int FRM_W  = $clog2(FRAMES_PER_SHIFT + 1);
  localparam int CNT_W  = vtpg_pkg::CNT_W;

  localparam logic [LINE_W-1:0] LINE_END = LINE_W'(TOTAL_LINES);
  localparam logic [LINE_W-1:0] ACT_END  = LINE_W'(ACTIVE_LINES);
  localparam logic [LINE_W-1:0] VS_BEG   = LINE_W'(ACTIVE_LINES + TOP_BLANK_LINES);
  localparam logic [LINE_W-1:0] VS_END   =
    LINE_W'(ACTIVE_LINES + TOP_BLANK_LINES + VSYNC_LINES);
  localparam logic [PIX_W-1:0]  PIX_END  = PIX_W'(PIXELS_PER_LINE);
  localparam logic [RIG_W-1:0]  RIG_END  = RIG_W'(ROWS_PER_SHIFT);
  localparam logic [FRM_W-1:0]  FRM_END  = FRM_W'(FRAMES_PER_SHIFT);

  typedef enum logic [2:0] {
    SEG_SYNC   = 3'd0,
    SEG_FRONT  = 3'd1,
    SEG_PIXELS = 3'd2,
    SEG_BACK   = 3'd3,
    SEG_REST   = 3'd4
  } seg_t;

  seg_t              seg_r,  seg_nxt;
  logic [CNT_W-1:0]  cnt_r,  cnt_nxt;
  logic [PIX_W-1:0]  pix_r,  pix_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [1:0]        rg_r,   rg_nxt;
  logic [RIG_W-1:0]  rig_r,  rig_nxt;
  logic [FRM_W-1:0]  frm_r,  frm_nxt;
  logic [1:0]        ofs_r,  ofs_nxt;

  logic              line_active;
  logic              line_vsync;
  logic [CNT_W-1:0]  seg_len;
  logic [CNT_W:0]    cnt_inc;
  logic [PIX_W-1:0]  pix_inc;
  logic [LINE_W-1:0] line_inc;
  logic [RIG_W-1:0]  rig_inc;
  logic [FRM_W-1:0]  frm_inc;
  logic              first;
  logic              step_en;
  logic              body_seg;
  vtpg_pkg::level_t  level;

  assign line_active = line_r < ACT_END;
  assign line_vsync  = (line_r >= VS_BEG) && (line_r < VS_END);
  assign first       = (seg_r == SEG_SYNC) && (cnt_r == '0);
  assign step_en     = step_i && tick_i;
  assign body_seg    = (seg_r == SEG_FRONT) || (seg_r == SEG_PIXELS) || (seg_r == SEG_BACK);

  // zero length acts as one tick
  always_comb begin
    unique case (seg_r)
      SEG_SYNC:   seg_len = cfg_i.hsync_ticks;
      SEG_FRONT:  seg_len = cfg_i.front_porch_ticks;
      SEG_PIXELS: seg_len = CNT_W'(cfg_i.pixel_ticks);
      SEG_BACK:   seg_len = cfg_i.back_porch_ticks;
      default:    seg_len = cfg_i.line_rest_ticks;
    endcase
    if (seg_len == '0) begin
      seg_len = CNT_W'(1);
    end
  end

  always_comb begin
    priority if (seg_r == SEG_SYNC) begin
      level = line_vsync ? vtpg_pkg::LVL_BLACK : vtpg_pkg::LVL_ZERO;
    end else if (seg_r == SEG_PIXELS) begin
      level = vtpg_pkg::pattern_level(ofs_r + rg_r + 2'(pix_r));
    end else if (seg_r == SEG_REST && line_vsync) begin
      level = vtpg_pkg::LVL_ZERO;
    end else begin
      level = vtpg_pkg::LVL_BLACK;
    end
  end

  assign res_o.level       = level;
  assign res_o.line_start  = tick_i && first;
  assign res_o.frame_start = tick_i && first && (line_r == '0);

  assign cnt_inc  = {1'b0, cnt_r} + (CNT_W+1)'(1);
  assign pix_inc  = pix_r + PIX_W'(1);
  assign line_inc = line_r + LINE_W'(1);
  assign rig_inc  = rig_r + RIG_W'(1);
  assign frm_inc  = frm_r + FRM_W'(1);

  always_comb begin
    seg_nxt  = seg_r;
    cnt_nxt  = cnt_r;
    pix_nxt  = pix_r;
    line_nxt = line_r;
    rg_nxt   = rg_r;
    rig_nxt  = rig_r;
    frm_nxt  = frm_r;
    ofs_nxt  = ofs_r;
    if (step_en) begin
      if (cnt_inc < {1'b0, seg_len}) begin
        cnt_nxt = cnt_inc[CNT_W-1:0];
      end else begin
        cnt_nxt = '0;
        unique case (seg_r)
          SEG_SYNC: begin
            seg_nxt = line_active ? SEG_FRONT : SEG_REST;
          end
          SEG_FRONT: begin
            seg_nxt = SEG_PIXELS;
            pix_nxt = '0;
          end
          SEG_PIXELS: begin
            if (pix_inc >= PIX_END) begin
              pix_nxt = '0;
              seg_nxt = SEG_BACK;
            end else begin
              pix_nxt = pix_inc;
            end
          end
          default: begin
            // end of line
            seg_nxt = SEG_SYNC;
            if (line_active) begin
              if (rig_inc >= RIG_END) begin
                rig_nxt = '0;
                rg_nxt  = rg_r + 2'd1;
              end else begin
                rig_nxt = rig_inc;
              end
            end
            if (line_inc >= LINE_END) begin
              line_nxt = '0;
              rg_nxt   = '0;
              rig_nxt  = '0;
              if (frm_inc >= FRM_END) begin
                frm_nxt = '0;
                ofs_nxt = ofs_r + 2'd1;
              end else begin
                frm_nxt = frm_inc;
              end
            end else begin
              line_nxt = line_inc;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r  <= SEG_SYNC;
      cnt_r  <= '0;
      pix_r  <= '0;
      line_r <= '0;
      rg_r   <= '0;
      rig_r  <= '0;
      frm_r  <= '0;
      ofs_r  <= '0;
    end else begin
      seg_r  <= seg_nxt;
      cnt_r  <= cnt_nxt;
      pix_r  <= pix_nxt;
      line_r <= line_nxt;
      rg_r   <= rg_nxt;
      rig_r  <= rig_nxt;
      frm_r  <= frm_nxt;
      ofs_r  <= ofs_nxt;
    end
  end

  `ASSERT_NEVER(a_pix_range, clk, rst_n, pix_r >= PIX_END)
  `ASSERT_NEVER(a_line_range, clk, rst_n, line_r >= LINE_END)
  `ASSERT_NEVER(a_porch_on_active, clk, rst_n, body_seg && !line_active)
  `ASSERT_PROP(a_hold, clk, rst_n, !step_en |=> $stable({cnt_r, seg_r, line_r}))

endmodule

// File: rtl/vtpg_out_reg.sv
// ---------------------------------------------------------------------------
// vtpg_out_reg
// result register between the timing logic and the output channel
// ---------------------------------------------------------------------------
module vtpg_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vtpg_pkg::result_t in_res,
  output logic              out_valid,
  input  logic              out_ready,
  output vtpg_pkg::result_t out_res
);

  logic              valid_r;
  vtpg_pkg::result_t res_r;

  // no transfer while in reset
  assign in_ready = rst_n && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_r <= in_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// File: rtl/video_timing_pattern_gen_core.sv
// ---------------------------------------------------------------------------
// video_timing_pattern_gen_core
// ntsc-style timing and stripe pattern generator, one level per tick
// ---------------------------------------------------------------------------
// result: registered, valid in the cycle after its input transfer
// throughput: one transfer per cycle while the output is not held, set by the single result register
// held output stalls the input only while the result register is full
// reset: synchronous, active low; restores register defaults and frame start
module video_timing_pattern_gen_core #(
  parameter int ACTIVE_LINES     = 242,
  parameter int PIXELS_PER_LINE  = 87,
  parameter int FRAMES_PER_SHIFT = 20,
  parameter int ROWS_PER_SHIFT   = 20,
  parameter int TOP_BLANK_LINES  = 5,
  parameter int VSYNC_LINES      = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [0] tick_enable
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [1:0] level, [2] line_start,
                                                      // [3] frame_start
  input  logic                            cfg_we,
  input  vtpg_pkg::cfg_idx_t              cfg_index,
  input  logic [vtpg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  vtpg_pkg::cfg_t    cfg;
  vtpg_pkg::result_t cur_res;
  vtpg_pkg::result_t out_res;
  logic              accept;

  assign accept = in_tvalid && in_tready;

  vtpg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  vtpg_timing #(
    .ACTIVE_LINES     (ACTIVE_LINES),
    .PIXELS_PER_LINE  (PIXELS_PER_LINE),
    .FRAMES_PER_SHIFT (FRAMES_PER_SHIFT),
    .ROWS_PER_SHIFT   (ROWS_PER_SHIFT),
    .TOP_BLANK_LINES  (TOP_BLANK_LINES),
    .VSYNC_LINES      (VSYNC_LINES)
  ) u_timing (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (accept),
    .tick_i (in_tdata[0]),
    .cfg_i  (cfg),
    .res_o  (cur_res)
  );

  vtpg_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_res    (cur_res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {4'b0000, out_res.frame_start, out_res.line_start, out_res.level};

endmodule
